FILE: sv/ols_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ols_pkg
// Shared constants, codes and types of the ordered list store.
// ----------------------------------------------------------------------------
package ols_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OP_W     = 3;
   localparam int POS_W    = 9;
   localparam int VAL_W    = 32;
   localparam int ST_W     = 2;
   localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 40;

   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_W-1:0] OP_READ   = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
   localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;
   localparam logic [OP_W-1:0] OP_COUNT  = 3'd5;

   localparam logic [ST_W-1:0] ST_OK   = 2'd0;
   localparam logic [ST_W-1:0] ST_MISS = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic             en;
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] key;
      logic [CNT_W-1:0] count;
   } ols_cmd_type;

   typedef struct packed {
      logic             any;
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] hit_value;
      logic [VAL_W-1:0] nxt_value;
   } ols_pick_type;

endpackage

FILE: sv/ols_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ols_cell
// One entry of the list: holds a value, loads on append, takes its right
// neighbor's value on delete, and flags a position or key hit.
// ----------------------------------------------------------------------------
module ols_cell (
   input  logic                      clock,
   input  ols_pkg::ols_cmd_type      cmd,
   input  logic [ols_pkg::IDX_W-1:0] idx,
   input  logic [ols_pkg::VAL_W-1:0] nbr_value,
   output logic [ols_pkg::VAL_W-1:0] value,
   output logic                      hit
);
   import ols_pkg::*;

   logic [VAL_W-1:0] value_ff, value_in;
   logic             hit_ff, hit_in;
   logic [CMP_W-1:0] idx_c, pos_c, cnt_c, idx_p1;
   logic             live, del_ok;

   always_comb begin
      idx_c    = CMP_W'(idx);
      pos_c    = CMP_W'(cmd.pos);
      cnt_c    = CMP_W'(cmd.count);
      idx_p1   = idx_c + CMP_W'(1);
      live     = idx_c < cnt_c;
      del_ok   = (pos_c != '0) && (pos_c <= cnt_c);
      value_in = value_ff;
      hit_in   = 1'b0;
      case (cmd.op)
         OP_APPEND: begin
            if (idx_c == cnt_c) value_in = cmd.key;
         end
         OP_DELETE: begin
            if (del_ok && idx_p1 >= pos_c && idx_p1 < cnt_c) value_in = nbr_value;
         end
         OP_READ: begin
            hit_in = live && (pos_c == idx_p1);
         end
         OP_FIND, OP_NEXT: begin
            hit_in = live && (value_ff == cmd.key);
         end
         default: begin
            hit_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         value_ff <= value_in;
         hit_ff   <= hit_in;
      end
   end

   assign value = value_ff;
   assign hit   = hit_ff;

endmodule

FILE: sv/ols_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ols_pick
// Reduces the cell hit flags: isolates the first hit, then encodes its
// position and selects its value and the value after it.
// ----------------------------------------------------------------------------
module ols_pick (
   input  logic                         clock,
   input  logic                         scan_en,
   input  logic                         pick_en,
   input  logic [ols_pkg::CAPACITY-1:0] hit,
   input  logic [ols_pkg::VAL_W-1:0]    value     [ols_pkg::CAPACITY],
   input  logic [ols_pkg::VAL_W-1:0]    nbr_value [ols_pkg::CAPACITY],
   output ols_pkg::ols_pick_type        pick
);
   import ols_pkg::*;

   logic [CAPACITY-1:0] first_ff, first_in;
   logic                any_ff;
   ols_pick_type        pick_ff, pick_in;

   // lowest set bit only
   assign first_in = hit & (~hit + CAPACITY'(1));

   always_comb begin
      pick_in     = '0;
      pick_in.any = any_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_ff[i]) begin
            pick_in.idx       = pick_in.idx | IDX_W'(i);
            pick_in.hit_value = pick_in.hit_value | value[i];
            pick_in.nxt_value = pick_in.nxt_value | nbr_value[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_en) begin
         first_ff <= first_in;
         any_ff   <= |hit;
      end
      if (pick_en) begin
         pick_ff <= pick_in;
      end
   end

   assign pick = pick_ff;

endmodule

FILE: sv/ordered_list_store.sv
`timescale 1ns / 1ps
// Sequence: a request is taken only in the idle state. Append, delete, count and
//   unused codes pass the cell update and then the done state; read, find and
//   next-after also pass the first-hit isolate and select stages in turn. The done
//   state waits for the output to be free; no new request is taken until then.
// Reset: entry count cleared; entry values stay undefined until written.
// ----------------------------------------------------------------------------
// ordered_list_store
// Bounded ordered list of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
module ordered_list_store (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [2:0] operation, [11:3] position, [43:12] value, [47:44] zero
   input  logic [ols_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [31:0] result_value, [33:32] status, [39:34] zero
   output logic [ols_pkg::RSP_W-1:0] rsp_tdata
);
   import ols_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_PICK = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [OP_W-1:0]  op_ff;
   logic [POS_W-1:0] pos_ff;
   logic [VAL_W-1:0] key_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [VAL_W-1:0] simple_res_ff, simple_res_in;
   logic [ST_W-1:0]  simple_st_ff, simple_st_in;
   logic             rsp_valid_ff;
   logic [VAL_W-1:0] rsp_res_ff, final_res;
   logic [ST_W-1:0]  rsp_st_ff, final_st;
   logic             out_free, accept;

   ols_cmd_type      cmd;
   ols_pick_type     pick;
   logic [CAPACITY-1:0] hit;
   logic [VAL_W-1:0] cell_value [CAPACITY];
   logic [VAL_W-1:0] nbr_value  [CAPACITY];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign cmd.en    = (state_ff == S_EVAL);
   assign cmd.op    = op_ff;
   assign cmd.pos   = pos_ff;
   assign cmd.key   = key_ff;
   assign cmd.count = count_ff;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         if (g == CAPACITY - 1) begin : g_end
            assign nbr_value[g] = '0;
         end else begin : g_mid
            assign nbr_value[g] = cell_value[g+1];
         end
         ols_cell u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .idx       (IDX_W'(g)),
            .nbr_value (nbr_value[g]),
            .value     (cell_value[g]),
            .hit       (hit[g])
         );
      end
   endgenerate

   ols_pick u_pick (
      .clock     (clock),
      .scan_en   (state_ff == S_SCAN),
      .pick_en   (state_ff == S_PICK),
      .hit       (hit),
      .value     (cell_value),
      .nbr_value (nbr_value),
      .pick      (pick)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      simple_res_in = simple_res_ff;
      simple_st_in  = simple_st_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EVAL;
         end
         S_EVAL: begin
            simple_res_in = '0;
            simple_st_in  = ST_OK;
            state_in      = S_DONE;
            case (op_ff)
               OP_APPEND: begin
                  if (count_ff == CNT_W'(CAPACITY)) simple_st_in = ST_FULL;
                  else count_in = count_ff + CNT_W'(1);
               end
               OP_DELETE: begin
                  if (pos_ff == '0 || CMP_W'(pos_ff) > CMP_W'(count_ff)) begin
                     simple_st_in = ST_MISS;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               OP_READ, OP_FIND, OP_NEXT: begin
                  state_in = S_SCAN;
               end
               OP_COUNT: begin
                  simple_res_in = VAL_W'(count_ff);
               end
               default: begin
                  simple_st_in = ST_MISS;
               end
            endcase
         end
         S_SCAN: state_in = S_PICK;
         S_PICK: state_in = S_DONE;
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      final_res = '0;
      final_st  = ST_MISS;
      case (op_ff)
         OP_READ: begin
            if (pick.any) begin
               final_res = pick.hit_value;
               final_st  = ST_OK;
            end
         end
         OP_FIND: begin
            if (pick.any) begin
               final_res = VAL_W'(pick.idx) + VAL_W'(1);
               final_st  = ST_OK;
            end
         end
         OP_NEXT: begin
            if (pick.any && (CMP_W'(pick.idx) + CMP_W'(1) < CMP_W'(count_ff))) begin
               final_res = pick.nxt_value;
               final_st  = ST_OK;
            end
         end
         default: begin
            final_res = simple_res_ff;
            final_st  = simple_st_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == S_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      simple_res_ff <= simple_res_in;
      simple_st_ff  <= simple_st_in;
      if (accept) begin
         op_ff  <= req_tdata[2:0];
         pos_ff <= req_tdata[11:3];
         key_ff <= req_tdata[43:12];
      end
      if (state_ff == S_DONE && out_free) begin
         rsp_res_ff <= final_res;
         rsp_st_ff  <= final_st;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - VAL_W - ST_W)'(0), rsp_st_ff, rsp_res_ff};

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EVAL)
      else $error("request taken without cell update");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_EVAL |=> $stable(count_ff))
      else $error("entry count moved outside update cycle");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_st_ff != 2'd3)
      else $error("undefined status code");
`endif

endmodule
